// ===== rtl/dq_pkg.sv =====
package dq_pkg;

  // Default ring size and the widths that follow from it.
  localparam int unsigned DepthDef = 16;
  localparam int unsigned OccWDef  = $clog2(DepthDef + 1);

  localparam int unsigned WordW = 32;

  typedef enum logic [1:0] {
    KIND_PUSH_FRONT = 2'd0,
    KIND_PUSH_REAR  = 2'd1,
    KIND_POP_FRONT  = 2'd2,
    KIND_POP_REAR   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef logic signed [WordW-1:0] word_t;

endpackage

// ===== rtl/dq_req_if.sv =====
interface dq_req_if;
  import dq_pkg::*;

  logic  valid;
  logic  ready;
  kind_e kind;
  word_t value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

// ===== rtl/dq_rsp_if.sv =====
interface dq_rsp_if #(
  parameter int unsigned OCC_W = dq_pkg::OccWDef
);
  import dq_pkg::*;

  logic             valid;
  logic             ready;
  status_e          status;
  word_t            removed_value;
  logic [OCC_W-1:0] occupancy;

  modport source (output valid, output status, output removed_value, output occupancy,
                  input ready);
  modport sink   (input valid, input status, input removed_value, input occupancy,
                  output ready);
endinterface

// ===== rtl/double_ended_queue_top.sv =====
// Bounded double-ended queue of signed 32-bit words. Each request item on req_i
// pushes a word at the front or the rear, or pops the word at the front or the
// rear, and yields exactly one response item on rsp_o with a status, the number
// of words held after the step and, for a successful pop, the word removed
// (zero otherwise). A pop from an empty queue answers "empty" and a push into a
// full queue answers "full" and drops the word; neither changes the contents.
// The words sit in a ring of DEPTH entries in a single-port-read, single-port-
// write RAM with a registered read, addressed by front and rear indices.
// The RAM read of a request is issued in the cycle the item is accepted and its
// registered data is used at completion, when the indices, the count and any
// push write are committed. A response register separates the two sides, so a
// new request is accepted while an earlier response still waits to be taken;
// the block then holds that request until the register frees.
// The rsp_o interface instance must be built with OCC_W equal to
// $clog2(DEPTH + 1). The RAM contents are not cleared at reset; no pop can reach
// a slot that has not been written by a push.
module double_ended_queue_top #(
  parameter int unsigned DEPTH = dq_pkg::DepthDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  dq_req_if.sink          req_i,
  dq_rsp_if.source        rsp_o
);
  import dq_pkg::*;

  localparam int unsigned IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  localparam logic [IdxW-1:0] IdxLast = IdxW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  // Ring indices and the fill count.
  logic [IdxW-1:0] front_q, front_d;
  logic [IdxW-1:0] rear_q, rear_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  // The request that is in flight between acceptance and completion.
  logic  busy_q, busy_d;
  kind_e kind_q;
  word_t value_q;

  // Response register.
  logic            rsp_valid_q, rsp_valid_d;
  status_e         status_q, status_d;
  word_t           removed_q, removed_d;
  logic [CntW-1:0] occ_q;

  // Neighbouring slots of each index, wrapping at the end of the ring.
  logic [IdxW-1:0] front_inc, front_dec, rear_inc, rear_dec;

  assign front_inc = (front_q == IdxLast) ? '0 : front_q + 1'b1;
  assign front_dec = (front_q == '0) ? IdxLast : front_q - 1'b1;
  assign rear_inc  = (rear_q == IdxLast) ? '0 : rear_q + 1'b1;
  assign rear_dec  = (rear_q == '0) ? IdxLast : rear_q - 1'b1;

  logic accept, complete, is_full, is_empty;

  // Only one request is in flight, so a read never meets a pending write to
  // the same slot: the write commits at an earlier edge than the next read.
  assign req_i.ready = !busy_q;
  assign accept      = req_i.valid && !busy_q;
  assign complete    = busy_q && (!rsp_valid_q || rsp_o.ready);
  assign is_full     = (cnt_q == CntFull);
  assign is_empty    = (cnt_q == '0);

  // The read is launched as the item is accepted. A pop at the rear reads the
  // slot just before the rear index, a pop at the front the front slot.
  logic            ram_re;
  logic [IdxW-1:0] ram_raddr;
  word_t           ram_rdata;
  logic            ram_we;
  logic [IdxW-1:0] ram_waddr;

  assign ram_re    = accept &&
                     ((req_i.kind == KIND_POP_FRONT) || (req_i.kind == KIND_POP_REAR));
  assign ram_raddr = (req_i.kind == KIND_POP_FRONT) ? front_q : rear_dec;

  dq_ram #(
    .WIDTH (WordW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (value_q),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Completion: update the indices and the count, write a pushed word, and
  // load the response register.
  always_comb begin
    front_d   = front_q;
    rear_d    = rear_q;
    cnt_d     = cnt_q;
    ram_we    = 1'b0;
    ram_waddr = rear_q;
    status_d  = ST_OK;
    removed_d = '0;

    unique case (kind_q)
      KIND_PUSH_FRONT: begin
        if (is_full) begin
          status_d = ST_FULL;
        end else begin
          ram_we    = complete;
          ram_waddr = front_dec;
          front_d   = front_dec;
          cnt_d     = cnt_q + 1'b1;
        end
      end
      KIND_PUSH_REAR: begin
        if (is_full) begin
          status_d = ST_FULL;
        end else begin
          ram_we    = complete;
          ram_waddr = rear_q;
          rear_d    = rear_inc;
          cnt_d     = cnt_q + 1'b1;
        end
      end
      KIND_POP_FRONT: begin
        if (is_empty) begin
          status_d = ST_EMPTY;
        end else begin
          removed_d = ram_rdata;
          front_d   = front_inc;
          cnt_d     = cnt_q - 1'b1;
        end
      end
      KIND_POP_REAR: begin
        if (is_empty) begin
          status_d = ST_EMPTY;
        end else begin
          removed_d = ram_rdata;
          rear_d    = rear_dec;
          cnt_d     = cnt_q - 1'b1;
        end
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  always_comb begin
    busy_d = busy_q;
    if (accept) begin
      busy_d = 1'b1;
    end else if (complete) begin
      busy_d = 1'b0;
    end

    rsp_valid_d = rsp_valid_q;
    if (complete) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q     <= '0;
      rear_q      <= '0;
      cnt_q       <= '0;
      busy_q      <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      rsp_valid_q <= rsp_valid_d;
      if (complete) begin
        front_q <= front_d;
        rear_q  <= rear_d;
        cnt_q   <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q  <= req_i.kind;
      value_q <= req_i.value;
    end
    if (complete) begin
      status_q  <= status_d;
      removed_q <= removed_d;
      occ_q     <= cnt_d;
    end
  end

  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.status        = status_q;
  assign rsp_o.removed_value = removed_q;
  assign rsp_o.occupancy     = occ_q;

  // The rear index always lies count slots past the front index.
  logic [CntW:0] span;
  logic [CntW:0] span_wrapped;

  assign span         = (CntW + 1)'(front_q) + (CntW + 1)'(cnt_q);
  assign span_wrapped = (span >= (CntW + 1)'(DEPTH)) ? span - (CntW + 1)'(DEPTH) : span;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntFull)
    else $error("queue count exceeds the ring size");

  a_ring_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    span_wrapped == (CntW + 1)'(rear_q))
    else $error("front index, rear index and count disagree");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && (status_q == ST_FULL) |-> (occ_q == CntFull))
    else $error("full status reported with room left");

  a_empty_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && (status_q == ST_EMPTY) |-> (occ_q == '0) && (removed_q == '0))
    else $error("empty status reported with words held or a word removed");

  a_pop_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    complete && !is_empty &&
    ((kind_q == KIND_POP_FRONT) || (kind_q == KIND_POP_REAR))
    |=> (cnt_q == $past(cnt_q) - 1'b1))
    else $error("successful pop did not reduce the count by one");

endmodule

// ===== rtl/dq_ram.sv =====
module dq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import dq_pkg::*;

  localparam int unsigned Depth       = DepthDef;
  localparam int unsigned OccW        = $clog2(Depth + 1);
  // A request passes through the block and then sits in the response register,
  // so SettleCycles quiet cycles at the end are ample to catch a stray reply.
  localparam int unsigned SettleCycles = 20;
  localparam int unsigned HoldCycles   = 200;

  typedef struct packed {
    status_e         status;
    word_t           removed_value;
    logic [OccW-1:0] occupancy;
  } deque_reply_t;

  logic clk_i;
  logic rst_ni;

  dq_req_if                  req_if ();
  dq_rsp_if #(.OCC_W(OccW))  rsp_if ();

  double_ended_queue_top #(
    .DEPTH (Depth)
  ) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Shadow copy of the ring. Indices wrap modulo Depth; the front index points
  // at the front word and the rear index just past the rear word.
  word_t        ring_words [Depth];
  int unsigned  front_slot;
  int unsigned  rear_slot;
  int unsigned  words_held;

  // Replies owed by the block, oldest first.
  deque_reply_t replies_due [$];

  int unsigned  fail_count;
  int unsigned  send_idle_pct;
  int unsigned  recv_idle_pct;
  // Bumped by the stimulus to ask the response side for a long hold-off.
  int unsigned  hold_request_seq;

  // Clock: 10 ns period.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // A hard ceiling on the run, well beyond the slowest correct run.
  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

  // Applies one request to the shadow ring and returns the reply it should give.
  // Pushes into a full ring and pops from an empty one leave everything as it is.
  function automatic deque_reply_t deque_apply(kind_e kind, word_t value);
    deque_reply_t reply;
    reply.status        = ST_OK;
    reply.removed_value = '0;
    case (kind)
      KIND_PUSH_FRONT: begin
        if (words_held >= Depth) begin
          reply.status = ST_FULL;
        end else begin
          front_slot = (front_slot + Depth - 1) % Depth;
          ring_words[front_slot] = value;
          words_held++;
        end
      end
      KIND_PUSH_REAR: begin
        if (words_held >= Depth) begin
          reply.status = ST_FULL;
        end else begin
          ring_words[rear_slot] = value;
          rear_slot = (rear_slot + 1) % Depth;
          words_held++;
        end
      end
      KIND_POP_FRONT: begin
        if (words_held == 0) begin
          reply.status = ST_EMPTY;
        end else begin
          reply.removed_value = ring_words[front_slot];
          front_slot = (front_slot + 1) % Depth;
          words_held--;
        end
      end
      default: begin
        if (words_held == 0) begin
          reply.status = ST_EMPTY;
        end else begin
          rear_slot = (rear_slot + Depth - 1) % Depth;
          reply.removed_value = ring_words[rear_slot];
          words_held--;
        end
      end
    endcase
    reply.occupancy = OccW'(words_held);
    return reply;
  endfunction

  // Both handshakes are sampled at the rising edge. A request accepted here is
  // turned into an owed reply; a reply accepted here is checked against the
  // oldest owed one. A reply never leaves in the cycle its request arrives.
  always @(posedge clk_i) begin : reply_check
    deque_reply_t want;
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        replies_due.push_back(deque_apply(req_if.kind, req_if.value));
      end
      if (rsp_if.valid && rsp_if.ready) begin
        if (replies_due.size() == 0) begin
          $error("reply item arrived with none owed");
          fail_count++;
        end else begin
          want = replies_due.pop_front();
          if (rsp_if.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp_if.status);
            fail_count++;
          end
          if (rsp_if.removed_value !== want.removed_value) begin
            $error("removed_value: expected %0d, got %0d", want.removed_value,
                   rsp_if.removed_value);
            fail_count++;
          end
          if (rsp_if.occupancy !== want.occupancy) begin
            $error("occupancy: expected %0d, got %0d", want.occupancy, rsp_if.occupancy);
            fail_count++;
          end
        end
      end
    end
  end

  // Response side. It stalls at random at the current rate, and on request
  // holds ready low for a long stretch that it counts itself.
  initial begin : reply_sink
    int unsigned hold_left;
    int unsigned hold_seen;
    hold_left     = 0;
    hold_seen     = 0;
    rsp_if.ready  = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_seen != hold_request_seq) begin
        hold_seen = hold_request_seq;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Offers one request item and returns at the edge where it is taken. Valid is
  // left high so that the next item follows without a gap unless one is drawn.
  task automatic send_request(input kind_e kind, input word_t value);
    int unsigned gap;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      gap = $urandom_range(1, 3);
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.kind  <= kind;
    req_if.value <= value;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
  endtask

  // Mostly random words, with the extremes mixed in now and then.
  function automatic word_t pick_word();
    case ($urandom_range(0, 15))
      0:       return {1'b1, {(WordW-1){1'b0}}};
      1:       return {1'b0, {(WordW-1){1'b1}}};
      2:       return '0;
      3:       return '1;
      default: return word_t'($urandom());
    endcase
  endfunction

  function automatic kind_e pick_kind(input int unsigned push_pct);
    if ($urandom_range(0, 99) < push_pct) begin
      return $urandom_range(0, 1) ? KIND_PUSH_REAR : KIND_PUSH_FRONT;
    end
    return $urandom_range(0, 1) ? KIND_POP_REAR : KIND_POP_FRONT;
  endfunction

  // Pops at either end of an empty queue must report empty and change nothing.
  task automatic test_empty_pops();
    send_request(KIND_POP_FRONT, '1);
    send_request(KIND_POP_REAR, '1);
  endtask

  // Fills the ring from both ends so that the front index wraps, then pushes into
  // the full ring at each end. The most negative and most positive words go in
  // last at the two ends, so the two pops that follow bring them straight back.
  task automatic test_fill_and_overflow();
    send_request(KIND_PUSH_REAR, '0);
    send_request(KIND_PUSH_FRONT, '1);
    for (int i = 0; i < Depth - 4; i++) begin
      send_request(i[0] ? KIND_PUSH_FRONT : KIND_PUSH_REAR, word_t'($urandom()));
    end
    send_request(KIND_PUSH_REAR, {1'b0, {(WordW-1){1'b1}}});
    send_request(KIND_PUSH_FRONT, {1'b1, {(WordW-1){1'b0}}});
    send_request(KIND_PUSH_FRONT, word_t'($urandom()));
    send_request(KIND_PUSH_REAR, word_t'($urandom()));
    send_request(KIND_POP_FRONT, '0);
    send_request(KIND_POP_REAR, '0);
  endtask

  // The response side holds off for a long stretch while requests keep coming,
  // so the block has to fill up and stall its request side.
  task automatic test_long_reply_hold();
    hold_request_seq++;
    repeat (24) send_request(pick_kind(50), pick_word());
  endtask

  // A burst, then a pause until every owed reply has been taken, then more.
  task automatic test_drain_pause();
    repeat (12) send_request(pick_kind(60), pick_word());
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (replies_due.size() != 0) @(posedge clk_i);
    repeat (12) send_request(pick_kind(40), pick_word());
  endtask

  // Random traffic in runs of 32 items. Each run leans towards pushes, towards
  // pops or neither, so the fill level wanders between empty and full and the
  // full and empty cases turn up regularly.
  task automatic test_random_traffic(input int unsigned count);
    int unsigned push_pct;
    for (int i = 0; i < count; i++) begin
      if (i % 32 == 0) begin
        case ($urandom_range(0, 2))
          0:       push_pct = 25;
          1:       push_pct = 50;
          default: push_pct = 75;
        endcase
      end
      send_request(pick_kind(push_pct), pick_word());
    end
  endtask

  // Waits for every owed reply, lets the block settle and gives the verdict.
  task automatic finish_run();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (replies_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  endtask

  initial begin : stimulus
    rst_ni           = 1'b0;
    req_if.valid     = 1'b0;
    req_if.kind      = KIND_PUSH_FRONT;
    req_if.value     = '0;
    front_slot       = 0;
    rear_slot        = 0;
    words_held       = 0;
    fail_count       = 0;
    hold_request_seq = 0;
    send_idle_pct    = 14;
    recv_idle_pct    = 61;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_pops();
    test_fill_and_overflow();
    test_long_reply_hold();
    test_random_traffic(260);

    send_idle_pct = 61;
    recv_idle_pct = 14;
    test_drain_pause();
    test_random_traffic(250);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(230);

    finish_run();
  end

endmodule
